FILE: src/dqcs_pkg.sv
`timescale 1ns / 1ps

package dqcs_pkg;

    // Number of cells in the chain.
    localparam int CAPACITY = 64;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 7;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd5;

    // Status codes returned with every result.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] popped_value;
        logic [OCNT_W-1:0]        entry_count;
        logic                     found;
    } t_out_item;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              shift_rear;   // every entry moves one cell toward the rear
        logic              shift_front;  // every entry moves one cell toward the front
        logic              write_rear;   // the first free cell takes the value
        logic [DATA_W-1:0] value;        // pushed value or search key
    } t_cell_ctl;

endpackage

FILE: src/deque_with_count_and_search_unit.sv
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle for every operation, as long as results are taken.
// The output register holds a stalled result; a new transfer is refused only then.
// Reset (synchronous, active low) empties the deque and drops any pending result;
// the cell contents are not cleared.

module deque_with_count_and_search_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dqcs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dqcs_pkg::t_out_item o_out_data
);

    // The deque is kept front aligned: cell zero always holds the front entry
    // and cells below the count hold the stored entries in order. A push or pop
    // at the front shifts the whole chain by one cell, each cell taking its
    // neighbor's value. A push at the rear writes the first free cell. A pop at
    // the rear only lowers the count; the cell that held the rear entry drives
    // its value on the tail bus, which is an OR over all cells.

    localparam int N = dqcs_pkg::CAPACITY;

    logic [dqcs_pkg::CNT_W-1:0]  r_count;
    logic [dqcs_pkg::CNT_W-1:0]  n_count;
    logic                        r_out_valid;
    dqcs_pkg::t_out_item         r_out;
    dqcs_pkg::t_out_item         n_out;
    dqcs_pkg::t_cell_ctl         cell_ctl;

    logic [dqcs_pkg::DATA_W-1:0] cell_value [N];
    logic [dqcs_pkg::DATA_W-1:0] cell_tail  [N];
    logic [N-1:0]                cell_hit;
    logic [dqcs_pkg::DATA_W-1:0] tail_value;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic [dqcs_pkg::CNT_W+dqcs_pkg::OCNT_W-1:0] count_wide;

    // A new item may enter unless a finished result is still waiting.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = r_count == dqcs_pkg::CNT_W'(N);
    assign empty = r_count == '0;

    // The chain of cells.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [dqcs_pkg::DATA_W-1:0] front_in;
        logic [dqcs_pkg::DATA_W-1:0] rear_in;

        if (g == 0) begin : g_first
            assign front_in = i_in_data.item_value;
        end else begin : g_inner
            assign front_in = cell_value[g-1];
        end

        if (g == N - 1) begin : g_last
            assign rear_in = '0;
        end else begin : g_body
            assign rear_in = cell_value[g+1];
        end

        dqcs_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_index       (dqcs_pkg::IDX_W'(g)),
            .i_count       (r_count),
            .i_front_value (front_in),
            .i_rear_value  (rear_in),
            .o_value       (cell_value[g]),
            .o_tail_value  (cell_tail[g]),
            .o_hit         (cell_hit[g])
        );
    end

    // Exactly one cell, or none when the deque is empty, drives the tail bus.
    always_comb begin
        tail_value = '0;
        for (int k = 0; k < N; k++) begin
            tail_value = tail_value | cell_tail[k];
        end
    end

    // Decode the operation, update the count and build the result.
    always_comb begin
        cell_ctl             = '0;
        cell_ctl.value       = i_in_data.item_value;
        n_count              = r_count;
        n_out                = '0;
        n_out.status         = dqcs_pkg::ST_OK;

        case (i_in_data.kind)
            dqcs_pkg::KIND_PUSH_FRONT: begin
                if (full) begin
                    n_out.status = dqcs_pkg::ST_FULL;
                end else begin
                    cell_ctl.shift_rear = accept;
                    n_count             = r_count + dqcs_pkg::CNT_W'(1);
                end
            end
            dqcs_pkg::KIND_POP_FRONT: begin
                if (empty) begin
                    n_out.status = dqcs_pkg::ST_EMPTY;
                end else begin
                    cell_ctl.shift_front = accept;
                    n_out.popped_value   = cell_value[0];
                    n_count              = r_count - dqcs_pkg::CNT_W'(1);
                end
            end
            dqcs_pkg::KIND_PUSH_REAR: begin
                if (full) begin
                    n_out.status = dqcs_pkg::ST_FULL;
                end else begin
                    cell_ctl.write_rear = accept;
                    n_count             = r_count + dqcs_pkg::CNT_W'(1);
                end
            end
            dqcs_pkg::KIND_POP_REAR: begin
                if (empty) begin
                    n_out.status = dqcs_pkg::ST_EMPTY;
                end else begin
                    n_out.popped_value = tail_value;
                    n_count            = r_count - dqcs_pkg::CNT_W'(1);
                end
            end
            dqcs_pkg::KIND_SEARCH: begin
                n_out.found = |cell_hit;
            end
            default: begin
                // The count request and the unused codes leave the deque alone.
            end
        endcase

        // The reported count keeps its low seven bits.
        count_wide        = {{dqcs_pkg::OCNT_W{1'b0}}, n_count};
        n_out.entry_count = count_wide[dqcs_pkg::OCNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; it changes only when a new transfer is taken in.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/dqcs_cell.sv
`timescale 1ns / 1ps

// One storage cell of the deque chain. Cell zero holds the front entry.
module dqcs_cell (
    input  logic                              i_clk,
    input  dqcs_pkg::t_cell_ctl               i_ctl,
    input  logic [dqcs_pkg::IDX_W-1:0]        i_index,
    input  logic [dqcs_pkg::CNT_W-1:0]        i_count,
    input  logic [dqcs_pkg::DATA_W-1:0]       i_front_value,
    input  logic [dqcs_pkg::DATA_W-1:0]       i_rear_value,
    output logic [dqcs_pkg::DATA_W-1:0]       o_value,
    output logic [dqcs_pkg::DATA_W-1:0]       o_tail_value,
    output logic                              o_hit
);

    logic [dqcs_pkg::DATA_W-1:0] r_value;
    logic [dqcs_pkg::DATA_W-1:0] n_value;
    logic [dqcs_pkg::CNT_W-1:0]  index_ext;
    logic                        occupied;
    logic                        is_tail;

    assign index_ext = dqcs_pkg::CNT_W'(i_index);
    assign occupied  = index_ext < i_count;
    assign is_tail   = (index_ext + dqcs_pkg::CNT_W'(1)) == i_count;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift_rear) begin
            n_value = i_front_value;
        end else if (i_ctl.shift_front) begin
            n_value = i_rear_value;
        end else if (i_ctl.write_rear && (index_ext == i_count)) begin
            n_value = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_tail_value = is_tail ? r_value : '0;
    assign o_hit        = occupied && (r_value == i_ctl.value);

endmodule

FILE: src/dqcs_checker.sv
`timescale 1ns / 1ps

module dqcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dqcs_pkg::t_out_item o_out_data
);

    // Every input transfer yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("input transfer produced no result");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A refused push happens only with a full deque.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == dqcs_pkg::ST_FULL))
        |-> (o_out_data.entry_count == dqcs_pkg::OCNT_W'(dqcs_pkg::CAPACITY)))
        else $error("full status with a count below capacity");

    // A refused pop happens only with an empty deque and returns zero.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == dqcs_pkg::ST_EMPTY))
        |-> ((o_out_data.entry_count == '0) && (o_out_data.popped_value == '0)))
        else $error("empty status with stored entries or a value");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind deque_with_count_and_search_unit dqcs_checker u_dqcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: tb/deque_with_count_and_search_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the deque unit. Every input transfer is fed to a
// behavioral copy of the deque kept in this module, and the result it gives
// is queued. Every output transfer is checked field by field against the
// oldest queued result. A short scripted sequence runs first, then a long
// random sequence.
module deque_with_count_and_search_unit_tb;
    import dqcs_pkg::*;

    // Kinds the block does not use. They must leave the deque alone.
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    // Where a script row takes its value from.
    localparam logic [1:0] VAL_LITERAL = 2'd0;
    localparam logic [1:0] VAL_RANDOM  = 2'd1;
    localparam logic [1:0] VAL_STORED  = 2'd2;

    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_TAIL    = 150;   // segments that start this close to the end run with no idling at all
    localparam int STUCK_LIMIT  = 2000;  // cycles with no transfer before the run is abandoned
    localparam int DRAIN_CYCLES = 4;     // extra cycles waited after the last expected result has come out

    // One row of the scripted sequence. The row is sent 'reps' times. When
    // has_result is set, the result is typed in and replaces the prediction.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [1:0]        value_src;
        logic [DATA_W-1:0] value;
        logic [7:0]        reps;
        logic              has_result;
        t_out_item         result;
    } t_script_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // A typed-in result travels alongside the input payload, so that the
    // monitor knows which transfer it belongs to.
    logic      row_has_result;
    t_out_item row_result;

    // Behavioral copy of the deque: a circular store with a front index and
    // a fill level.
    logic signed [DATA_W-1:0] model_cells [CAPACITY];
    int model_head = 0;
    int model_fill = 0;

    t_out_item   pending_results[$];
    t_script_row script[$];

    bit calm = 1'b0;  // when set, neither side idles or stalls
    int errors       = 0;
    int transfers_in = 0;
    int results_seen = 0;
    int full_seen    = 0;
    int empty_seen   = 0;
    int hits_seen    = 0;
    int stuck_cycles = 0;

    deque_with_count_and_search_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one operation to the behavioral deque and returns the result
    // that the block must produce for it.
    function automatic t_out_item apply_deque_op(input t_in_item op);
        t_out_item r;
        int slot;
        int i;
        r = '0;
        case (op.kind)
            KIND_PUSH_FRONT: begin
                if (model_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    model_head = (model_head + CAPACITY - 1) % CAPACITY;
                    model_cells[model_head] = op.item_value;
                    model_fill++;
                end
            end
            KIND_POP_FRONT: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = model_cells[model_head];
                    model_head = (model_head + 1) % CAPACITY;
                    model_fill--;
                end
            end
            KIND_PUSH_REAR: begin
                if (model_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (model_head + model_fill) % CAPACITY;
                    model_cells[slot] = op.item_value;
                    model_fill++;
                end
            end
            KIND_POP_REAR: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = (model_head + model_fill - 1) % CAPACITY;
                    r.popped_value = model_cells[slot];
                    model_fill--;
                end
            end
            KIND_SEARCH: begin
                for (i = 0; i < model_fill; i++) begin
                    if (model_cells[(model_head + i) % CAPACITY] == op.item_value) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: begin
                // Count and the spare kinds change nothing.
            end
        endcase
        r.entry_count = OCNT_W'(model_fill);
        return r;
    endfunction

    // A value that currently sits in the deque, so that searches can hit.
    function automatic logic signed [DATA_W-1:0] stored_key();
        return model_cells[(model_head + $urandom_range(0, model_fill - 1)) % CAPACITY];
    endfunction

    // Mostly full-range values, with a small pool that makes duplicates
    // likely and the signed extremes now and then.
    function automatic logic signed [DATA_W-1:0] pick_value(input logic [KIND_W-1:0] kind);
        int r;
        r = $urandom_range(0, 99);
        if (kind == KIND_SEARCH && model_fill != 0 && r < 50) begin
            return stored_key();
        end
        if (r < 70) begin
            return $urandom;
        end
        if (r < 90) begin
            return $urandom_range(0, 4) - 2;
        end
        case (r % 4)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic t_out_item outcome(input logic [STAT_W-1:0] status,
                                          input logic [DATA_W-1:0] popped,
                                          input int fill, input logic hit);
        t_out_item r;
        r.status       = status;
        r.popped_value = popped;
        r.entry_count  = OCNT_W'(fill);
        r.found        = hit;
        return r;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [1:0] src,
                                    input logic [DATA_W-1:0] value, input int reps,
                                    input logic has_result, input t_out_item result);
        t_script_row row;
        row.kind       = kind;
        row.value_src  = src;
        row.value      = value;
        row.reps       = 8'(reps);
        row.has_result = has_result;
        row.result     = result;
        script.push_back(row);
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // Valid is left high, so back-to-back items need no extra assignment;
    // an idle burst lowers it first.
    task automatic send_item(input t_in_item op, input logic has_result,
                             input t_out_item result);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_data      <= op;
        row_has_result <= has_result;
        row_result     <= result;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // The result side stalls in bursts, except while the bench runs calm.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Monitor. Both channels are sampled at the rising edge, before the
    // block's own registers update. The output transfer is checked before
    // the input transfer of the same edge is predicted, since a result can
    // never come out in the cycle its item goes in.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (o_out_data.status == ST_FULL) full_seen++;
                if (o_out_data.status == ST_EMPTY) empty_seen++;
                if (o_out_data.found) hits_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: status %0d value %0d count %0d found %0b",
                             $time, o_out_data.status, o_out_data.popped_value,
                             o_out_data.entry_count, o_out_data.found);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, o_out_data.status);
                        errors++;
                    end
                    if (o_out_data.popped_value !== want.popped_value) begin
                        $display("%0t: popped_value expected %0d, actual %0d",
                                 $time, want.popped_value, o_out_data.popped_value);
                        errors++;
                    end
                    if (o_out_data.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, want.entry_count, o_out_data.entry_count);
                        errors++;
                    end
                    if (o_out_data.found !== want.found) begin
                        $display("%0t: found expected %0b, actual %0b",
                                 $time, want.found, o_out_data.found);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                transfers_in++;
                // The model always advances; a typed-in result only replaces
                // what gets compared.
                want = apply_deque_op(i_in_data);
                if (row_has_result) want = row_result;
                pending_results.push_back(want);
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_script_row row;
        t_in_item    op;
        int seg_len;
        int push_w;
        int pop_w;
        int r;
        int done_random;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        row_has_result = 1'b0;
        row_result     = '0;
        done_random    = 0;

        // Scripted part. Results that are obvious from the operation alone
        // are typed in; the bulk fill and drain rows rely on the prediction.
        // Both ends empty right after reset.
        add_row(KIND_POP_FRONT, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_EMPTY, '0, 0, 1'b0));
        add_row(KIND_POP_REAR, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_EMPTY, '0, 0, 1'b0));
        add_row(KIND_COUNT, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, 0, 1'b0));
        // A search of an empty deque never hits, even for a zero key.
        add_row(KIND_SEARCH, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, 0, 1'b0));
        add_row(KIND_SPARE_6, VAL_LITERAL, 32'hFFFF_FFFF, 1, 1'b1,
                outcome(ST_OK, '0, 0, 1'b0));
        add_row(KIND_SPARE_7, VAL_LITERAL, 32'h5555_5555, 1, 1'b1,
                outcome(ST_OK, '0, 0, 1'b0));
        // A single entry leaves by the opposite end, for both pairings.
        add_row(KIND_PUSH_FRONT, VAL_LITERAL, 32'h7FFF_FFFF, 1, 1'b1,
                outcome(ST_OK, '0, 1, 1'b0));
        add_row(KIND_POP_REAR, VAL_LITERAL, '0, 1, 1'b1,
                outcome(ST_OK, 32'h7FFF_FFFF, 0, 1'b0));
        add_row(KIND_PUSH_REAR, VAL_LITERAL, 32'h8000_0000, 1, 1'b1,
                outcome(ST_OK, '0, 1, 1'b0));
        add_row(KIND_POP_FRONT, VAL_LITERAL, '0, 1, 1'b1,
                outcome(ST_OK, 32'h8000_0000, 0, 1'b0));
        // Two entries, searched for both of them and for a miss.
        add_row(KIND_PUSH_FRONT, VAL_LITERAL, 32'hFFFF_FFFF, 1, 1'b1,
                outcome(ST_OK, '0, 1, 1'b0));
        add_row(KIND_PUSH_REAR, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, 2, 1'b0));
        add_row(KIND_SEARCH, VAL_LITERAL, 32'hFFFF_FFFF, 1, 1'b1,
                outcome(ST_OK, '0, 2, 1'b1));
        add_row(KIND_SEARCH, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, 2, 1'b1));
        add_row(KIND_SEARCH, VAL_LITERAL, 32'h0000_0001, 1, 1'b1,
                outcome(ST_OK, '0, 2, 1'b0));
        add_row(KIND_POP_FRONT, VAL_LITERAL, '0, 1, 1'b1,
                outcome(ST_OK, 32'hFFFF_FFFF, 1, 1'b0));
        add_row(KIND_POP_FRONT, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, 0, 1'b0));
        // Fill from both ends so the front index wraps, then push into a
        // full deque at both ends.
        add_row(KIND_PUSH_FRONT, VAL_RANDOM, '0, 40, 1'b0, '0);
        add_row(KIND_PUSH_REAR, VAL_RANDOM, '0, CAPACITY - 40, 1'b0, '0);
        add_row(KIND_PUSH_REAR, VAL_LITERAL, 32'hAAAA_AAAA, 1, 1'b1,
                outcome(ST_FULL, '0, CAPACITY, 1'b0));
        add_row(KIND_PUSH_FRONT, VAL_LITERAL, 32'h7FFF_FFFF, 1, 1'b1,
                outcome(ST_FULL, '0, CAPACITY, 1'b0));
        add_row(KIND_SEARCH, VAL_STORED, '0, 1, 1'b0, '0);
        add_row(KIND_COUNT, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_OK, '0, CAPACITY, 1'b0));
        // Drain from both ends, then one pop too many.
        add_row(KIND_POP_REAR, VAL_LITERAL, '0, 33, 1'b0, '0);
        add_row(KIND_POP_FRONT, VAL_LITERAL, '0, CAPACITY - 33, 1'b0, '0);
        add_row(KIND_POP_REAR, VAL_LITERAL, '0, 1, 1'b1, outcome(ST_EMPTY, '0, 0, 1'b0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[n]) begin
            row = script[n];
            repeat (row.reps) begin
                op.kind = row.kind;
                case (row.value_src)
                    VAL_RANDOM: op.item_value = $urandom;
                    VAL_STORED: op.item_value = stored_key();
                    default:    op.item_value = row.value;
                endcase
                send_item(op, row.has_result, row.result);
            end
        end

        // Random part, in segments that lean toward filling, draining or
        // neither, so that the deque swings between empty and full. Some
        // segments run calm, and so does the whole tail.
        while (done_random < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 90);
            case ($urandom_range(0, 2))
                0: begin
                    push_w = 45;
                    pop_w  = 35;
                end
                1: begin
                    push_w = 80;
                    pop_w  = 10;
                end
                default: begin
                    push_w = 10;
                    pop_w  = 80;
                end
            endcase
            calm = ($urandom_range(0, 3) == 0) || (done_random >= RANDOM_ITEMS - CALM_TAIL);
            repeat (seg_len) begin
                r = $urandom_range(0, 99);
                if (r < push_w) begin
                    op.kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
                end else if (r < push_w + pop_w) begin
                    op.kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 2) begin
                        op.kind = KIND_COUNT;
                    end else if (r < 3) begin
                        op.kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
                    end else begin
                        op.kind = KIND_SEARCH;
                    end
                end
                op.item_value = pick_value(op.kind);
                send_item(op, 1'b0, '0);
                done_random++;
            end
        end

        // Everything is sent; let the last results come out, then keep the clock
        // running so that any stray result still shows.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d input transfers and %0d checked results, %0d errors.",
                 transfers_in, results_seen, errors);
        $display("Saw %0d refused pushes on a full deque, %0d pops on an empty one, %0d search hits.",
                 full_seen, empty_seen, hits_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
